### rtl/ikod_pkg.sv
// Shared types, codes and field widths for the ID-keyed ordered deque.
package ikod_pkg;

  localparam int unsigned IKOD_DEPTH = 16;

  localparam int unsigned FUNC_W   = 3;
  localparam int unsigned ID_W     = 64;
  localparam int unsigned HANDLE_W = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned TOTAL_W  = 5;
  localparam int unsigned ENTRY_W  = ID_W + HANDLE_W;
  localparam int unsigned IN_W     = 96;
  localparam int unsigned OUT_W    = 104;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUSH_TAIL = 3'd0,
    FUNC_PUSH_HEAD = 3'd1,
    FUNC_REMOVE    = 3'd2,
    FUNC_POP_HEAD  = 3'd3,
    FUNC_POP_TAIL  = 3'd4,
    FUNC_FIND      = 3'd5,
    FUNC_PEEK_HEAD = 3'd6,
    FUNC_PEEK_TAIL = 3'd7
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic [ID_W-1:0]     id;
    logic [HANDLE_W-1:0] handle;
  } entry_t;

endpackage

### rtl/id_keyed_ordered_deque.sv
// Top level of the ID-keyed ordered deque: sequencer around one entry memory.
//
// The block keeps an ordered list of up to DEPTH entries, each a 64-bit ID and
// a 32-bit handle, in one synchronous memory used as a ring with a head pointer.
// Requests arrive on the slave stream: tuser carries the operation code, tdata
// the ID and handle. Every request produces exactly one transaction on the
// master stream with status, ID, handle and the entry count after the operation.
// One request is worked on at a time; a new one is taken once the result has
// moved into the output register.
// Pushes and any operation on an empty list go from the execute state straight
// to the result; pops and peeks first read one entry from memory. Find and
// remove read one entry per cycle, starting at the head; a find stops at the
// first match, and a miss reads the whole list. A remove that hits then moves
// every entry behind the match one slot toward the head, one per cycle. The
// next request can be taken as soon as the result is valid.
// Reset empties the list at once; no clearing pass is needed. While the
// receiver stalls, the result stays in the output register and the next
// request finishes up to the point of delivery, then waits.
module id_keyed_ordered_deque
  import ikod_pkg::*;
#(
  parameter int unsigned DEPTH = IKOD_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [IN_W-1:0]  s_axis_tdata,   // item_id[63:0], item_handle[95:64]
  input  logic [FUNC_W-1:0] s_axis_tuser,  // func[2:0]
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [OUT_W-1:0] m_axis_tdata    // status, found_id, found_handle, entry_total, pad
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW:0]   DEPTH_A = (AW+1)'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [AW-1:0] LAST_A  = AW'(DEPTH - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_RDATA,
    S_SCAN,
    S_SHIFT,
    S_DONE
  } state_e;

  function automatic logic [AW-1:0] ring_addr(input logic [AW-1:0] base,
                                              input logic [AW-1:0] off);
    logic [AW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= DEPTH_A) begin
      sum = sum - DEPTH_A;
    end
    return sum[AW-1:0];
  endfunction

  state_e              state_q, state_d;
  logic [AW-1:0]       head_q, head_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  func_e               func_q, func_d;
  logic [ID_W-1:0]     key_q, key_d;
  logic [HANDLE_W-1:0] hdl_q, hdl_d;
  logic [CW-1:0]       idx_q, idx_d;
  logic                cmp_vld_q, cmp_vld_d;
  logic [CW-1:0]       cmp_idx_q, cmp_idx_d;
  logic [CW-1:0]       pos_q, pos_d;
  status_e             res_status_q, res_status_d;
  entry_t              res_entry_q, res_entry_d;
  logic                m_vld_q, m_vld_d;
  logic [OUT_W-1:0]    m_data_q, m_data_d;

  entry_t              mem [DEPTH];
  entry_t              rd_q;
  logic                mem_we, mem_re;
  logic [AW-1:0]       mem_waddr, mem_raddr;
  entry_t              mem_wdata;

  logic [CW-1:0]       cnt_m1;
  logic [CW-1:0]       pos_p1;
  logic [CW-1:0]       pos_p2;
  logic [AW-1:0]       head_dec;

  assign cnt_m1   = cnt_q - 1'b1;
  assign pos_p1   = pos_q + 1'b1;
  assign pos_p2   = pos_q + CW'(2);
  assign head_dec = (head_q == '0) ? LAST_A : head_q - 1'b1;

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_vld_q;
  assign m_axis_tdata  = m_data_q;

  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    cnt_d        = cnt_q;
    func_d       = func_q;
    key_d        = key_q;
    hdl_d        = hdl_q;
    idx_d        = idx_q;
    cmp_vld_d    = 1'b0;
    cmp_idx_d    = cmp_idx_q;
    pos_d        = pos_q;
    res_status_d = res_status_q;
    res_entry_d  = res_entry_q;
    m_vld_d      = m_vld_q & ~m_axis_tready;
    m_data_d     = m_data_q;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_waddr    = head_q;
    mem_raddr    = head_q;
    mem_wdata    = '{id: key_q, handle: hdl_q};

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          func_d  = func_e'(s_axis_tuser);
          key_d   = s_axis_tdata[ID_W-1:0];
          hdl_d   = s_axis_tdata[ENTRY_W-1:ID_W];
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        res_status_d = STATUS_OK;
        res_entry_d  = '0;
        case (func_q)
          FUNC_PUSH_TAIL, FUNC_PUSH_HEAD: begin
            state_d = S_DONE;
            if (cnt_q == DEPTH_C) begin
              res_status_d = STATUS_FULL;
            end else begin
              mem_we = 1'b1;
              cnt_d  = cnt_q + 1'b1;
              if (func_q == FUNC_PUSH_TAIL) begin
                mem_waddr = ring_addr(head_q, cnt_q[AW-1:0]);
              end else begin
                mem_waddr = head_dec;
                head_d    = head_dec;
              end
            end
          end
          FUNC_REMOVE, FUNC_FIND: begin
            if (cnt_q == '0) begin
              res_status_d = STATUS_EMPTY;
              state_d      = S_DONE;
            end else begin
              idx_d   = '0;
              state_d = S_SCAN;
            end
          end
          default: begin
            if (cnt_q == '0) begin
              res_status_d = STATUS_EMPTY;
              state_d      = S_DONE;
            end else begin
              mem_re = 1'b1;
              if (func_q == FUNC_POP_TAIL || func_q == FUNC_PEEK_TAIL) begin
                mem_raddr = ring_addr(head_q, cnt_m1[AW-1:0]);
              end
              state_d = S_RDATA;
            end
          end
        endcase
      end

      S_RDATA: begin
        res_entry_d = rd_q;
        state_d     = S_DONE;
        if (func_q == FUNC_POP_HEAD) begin
          head_d = ring_addr(head_q, AW'(1));
          cnt_d  = cnt_m1;
        end else if (func_q == FUNC_POP_TAIL) begin
          cnt_d = cnt_m1;
        end
      end

      S_SCAN: begin
        if (idx_q < cnt_q) begin
          mem_re    = 1'b1;
          mem_raddr = ring_addr(head_q, idx_q[AW-1:0]);
          idx_d     = idx_q + 1'b1;
          cmp_vld_d = 1'b1;
          cmp_idx_d = idx_q;
        end
        if (cmp_vld_q) begin
          if (rd_q.id == key_q) begin
            cmp_vld_d   = 1'b0;
            res_entry_d = rd_q;
            if (func_q == FUNC_FIND) begin
              state_d = S_DONE;
            end else if (cmp_idx_q == cnt_m1) begin
              cnt_d   = cnt_m1;
              state_d = S_DONE;
            end else begin
              pos_d   = cmp_idx_q;
              state_d = S_SHIFT;
            end
          end else if (cmp_idx_q == cnt_m1) begin
            res_status_d = STATUS_EMPTY;
            state_d      = S_DONE;
          end
        end
      end

      S_SHIFT: begin
        mem_we    = 1'b1;
        mem_waddr = ring_addr(head_q, pos_q[AW-1:0]);
        mem_wdata = rd_q;
        pos_d     = pos_p1;
        if (pos_p2 < cnt_q) begin
          mem_re    = 1'b1;
          mem_raddr = ring_addr(head_q, pos_p2[AW-1:0]);
        end
        if (pos_p1 == cnt_m1) begin
          cnt_d   = cnt_m1;
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        if (!m_vld_q || m_axis_tready) begin
          m_vld_d  = 1'b1;
          m_data_d = {1'b0, TOTAL_W'(cnt_q), res_entry_q.handle, res_entry_q.id,
                      res_status_q};
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      head_q    <= '0;
      cnt_q     <= '0;
      cmp_vld_q <= 1'b0;
      m_vld_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      cnt_q     <= cnt_d;
      cmp_vld_q <= cmp_vld_d;
      m_vld_q   <= m_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q       <= func_d;
    key_q        <= key_d;
    hdl_q        <= hdl_d;
    idx_q        <= idx_d;
    cmp_idx_q    <= cmp_idx_d;
    pos_q        <= pos_d;
    res_status_q <= res_status_d;
    res_entry_q  <= res_entry_d;
    m_data_q     <= m_data_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem[mem_raddr];
    end
  end

endmodule

### rtl/ikod_checker.sv
// Port-level assertions for the ID-keyed ordered deque and their binding.
module ikod_checker
  import ikod_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              s_axis_tvalid,
  input logic              s_axis_tready,
  input logic [IN_W-1:0]   s_axis_tdata,
  input logic [FUNC_W-1:0] s_axis_tuser,
  input logic              m_axis_tvalid,
  input logic              m_axis_tready,
  input logic [OUT_W-1:0]  m_axis_tdata
);

  logic [STATUS_W-1:0] out_status;
  logic                out_zero;

  assign out_status = m_axis_tdata[STATUS_W-1:0];
  assign out_zero   = (m_axis_tdata[STATUS_W+ENTRY_W-1:STATUS_W] == '0);

  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("Result changed while the receiver stalled.");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (out_status == STATUS_OK || out_status == STATUS_EMPTY ||
                       out_status == STATUS_FULL))
    else $error("Result carries an undefined status code.");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && out_status != STATUS_OK |-> out_zero)
    else $error("Failed operation returned a nonzero ID or handle.");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("A second request was taken while one was in progress.");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !m_axis_tdata[OUT_W-1])
    else $error("Padding bit of the result is set.");

endmodule

bind id_keyed_ordered_deque ikod_checker u_ikod_checker (.*);

### tb/id_keyed_ordered_deque_tb.sv
// Self-checking testbench for the ID-keyed ordered deque with a queue-based list predictor.
module id_keyed_ordered_deque_tb;
  import ikod_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam int unsigned RANDOM_ITEMS = 1000;
  localparam int unsigned SETTLE_CYCLES = 2 * IKOD_DEPTH + 8;
  localparam int unsigned POOL_SIZE    = 8;
  localparam int unsigned STATUS_LSB   = 0;
  localparam int unsigned ID_LSB       = STATUS_LSB + STATUS_W;
  localparam int unsigned HANDLE_LSB   = ID_LSB + ID_W;
  localparam int unsigned TOTAL_LSB    = HANDLE_LSB + HANDLE_W;
  localparam int SRC_IDLE[4]   = '{0, 62, 0, 23};
  localparam int SINK_STALL[4] = '{0, 0, 62, 23};

  typedef struct {
    status_e             status;
    logic [ID_W-1:0]     id;
    logic [HANDLE_W-1:0] handle;
    logic [TOTAL_W-1:0]  total;
  } result_t;

  typedef struct {
    func_e               func;
    logic [ID_W-1:0]     id;
    logic [HANDLE_W-1:0] handle;
    int unsigned         reps;
    bit                  typed;
    status_e             status;
    logic [TOTAL_W-1:0]  total;
  } op_row_t;

  logic              clk_i;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [IN_W-1:0]   s_axis_tdata = '0;
  logic [FUNC_W-1:0] s_axis_tuser = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [OUT_W-1:0]  m_axis_tdata;

  entry_t      list_entries[$];
  result_t     pending_results[$];
  op_row_t     directed_ops[$];
  logic [ID_W-1:0] id_pool[POOL_SIZE];
  int unsigned src_idle_pct = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  bit          fill_mode = 1'b1;

  id_keyed_ordered_deque i_dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  function automatic result_t list_apply(func_e op, logic [ID_W-1:0] key,
                                         logic [HANDLE_W-1:0] hdl);
    result_t r;
    entry_t  e;
    int      pos;
    r.status = STATUS_OK;
    r.id = '0;
    r.handle = '0;
    pos = -1;
    e.id = key;
    e.handle = hdl;
    case (op)
      FUNC_PUSH_TAIL, FUNC_PUSH_HEAD: begin
        if (list_entries.size() >= IKOD_DEPTH) r.status = STATUS_FULL;
        else if (op == FUNC_PUSH_TAIL) list_entries.push_back(e);
        else list_entries.push_front(e);
      end
      FUNC_REMOVE, FUNC_FIND: begin
        for (int i = 0; i < list_entries.size(); i++) begin
          if (pos < 0 && list_entries[i].id == key) pos = i;
        end
      end
      FUNC_POP_HEAD, FUNC_PEEK_HEAD: begin
        if (list_entries.size() > 0) pos = 0;
      end
      default: begin
        if (list_entries.size() > 0) pos = list_entries.size() - 1;
      end
    endcase
    if (op != FUNC_PUSH_TAIL && op != FUNC_PUSH_HEAD) begin
      if (pos < 0) begin
        r.status = STATUS_EMPTY;
      end else begin
        r.id = list_entries[pos].id;
        r.handle = list_entries[pos].handle;
        if (op == FUNC_REMOVE || op == FUNC_POP_HEAD || op == FUNC_POP_TAIL)
          list_entries.delete(pos);
      end
    end
    r.total = TOTAL_W'(list_entries.size());
    return r;
  endfunction

  function automatic void add_row(func_e op, logic [ID_W-1:0] key, logic [HANDLE_W-1:0] hdl,
                                  int unsigned reps, bit typed, status_e st,
                                  int unsigned total);
    op_row_t row;
    row.func = op;
    row.id = key;
    row.handle = hdl;
    row.reps = reps;
    row.typed = typed;
    row.status = st;
    row.total = TOTAL_W'(total);
    directed_ops.push_back(row);
  endfunction

  function automatic op_row_t random_op();
    op_row_t     row;
    int unsigned push_pct;
    if (list_entries.size() >= IKOD_DEPTH) fill_mode = 1'b0;
    else if (list_entries.size() == 0) fill_mode = 1'b1;
    else if ($urandom_range(99) < 2) fill_mode = !fill_mode;
    push_pct = fill_mode ? 65 : 25;
    if ($urandom_range(99) < push_pct)
      row.func = $urandom_range(1) ? FUNC_PUSH_HEAD : FUNC_PUSH_TAIL;
    else
      row.func = func_e'($urandom_range(int'(FUNC_PEEK_TAIL), int'(FUNC_REMOVE)));
    if ($urandom_range(3) != 0) row.id = id_pool[$urandom_range(POOL_SIZE - 1)];
    else row.id = {$urandom(), $urandom()};
    row.handle = $urandom();
    row.reps = 1;
    row.typed = 1'b0;
    row.status = STATUS_OK;
    row.total = '0;
    return row;
  endfunction

  task automatic send_op(op_row_t row);
    result_t predicted;
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {row.handle, row.id};
    s_axis_tuser <= row.func;
    @(negedge clk_i);
    while (!s_axis_tready) @(negedge clk_i);
    predicted = list_apply(row.func, row.id, row.handle);
    if (row.typed) begin
      predicted.status = row.status;
      predicted.id = '0;
      predicted.handle = '0;
      predicted.total = row.total;
    end
    pending_results.push_back(predicted);
    @(posedge clk_i);
  endtask

  always @(negedge clk_i) begin
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transaction, tdata %h", m_axis_tdata);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[STATUS_LSB +: STATUS_W] !== want.status) begin
          $error("status expected %0d actual %0d", want.status,
                 m_axis_tdata[STATUS_LSB +: STATUS_W]);
          mismatch_count++;
        end
        if (m_axis_tdata[ID_LSB +: ID_W] !== want.id) begin
          $error("found_id expected %h actual %h", want.id, m_axis_tdata[ID_LSB +: ID_W]);
          mismatch_count++;
        end
        if (m_axis_tdata[HANDLE_LSB +: HANDLE_W] !== want.handle) begin
          $error("found_handle expected %h actual %h", want.handle,
                 m_axis_tdata[HANDLE_LSB +: HANDLE_W]);
          mismatch_count++;
        end
        if (m_axis_tdata[TOTAL_LSB +: TOTAL_W] !== want.total) begin
          $error("entry_total expected %0d actual %0d", want.total,
                 m_axis_tdata[TOTAL_LSB +: TOTAL_W]);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    op_row_t row;
    // Empty list, then the ID and handle extremes, repeated IDs, a full list and drops.
    add_row(FUNC_POP_HEAD,  '0, '0, 1, 1'b1, STATUS_EMPTY, 0);
    add_row(FUNC_POP_TAIL,  '0, '0, 1, 1'b1, STATUS_EMPTY, 0);
    add_row(FUNC_PEEK_HEAD, '0, '0, 1, 1'b1, STATUS_EMPTY, 0);
    add_row(FUNC_PEEK_TAIL, '0, '0, 1, 1'b1, STATUS_EMPTY, 0);
    add_row(FUNC_FIND,      '1, '0, 1, 1'b1, STATUS_EMPTY, 0);
    add_row(FUNC_REMOVE,    '1, '0, 1, 1'b1, STATUS_EMPTY, 0);
    add_row(FUNC_PUSH_TAIL, '1, '1, 1, 1'b1, STATUS_OK, 1);
    add_row(FUNC_PUSH_HEAD, '0, '0, 1, 1'b1, STATUS_OK, 2);
    add_row(FUNC_PEEK_HEAD, '0, '0, 1, 1'b0, STATUS_OK, 0);
    add_row(FUNC_PEEK_TAIL, '0, '0, 1, 1'b0, STATUS_OK, 0);
    add_row(FUNC_FIND,      '1, '0, 1, 1'b0, STATUS_OK, 0);
    add_row(FUNC_PUSH_TAIL, '0, 32'h5a5a_a5a5, 1, 1'b1, STATUS_OK, 3);
    add_row(FUNC_REMOVE,    '0, '0, 1, 1'b0, STATUS_OK, 0);
    add_row(FUNC_POP_TAIL,  '0, '0, 1, 1'b0, STATUS_OK, 0);
    add_row(FUNC_FIND,      64'h1234, '0, 1, 1'b0, STATUS_OK, 0);
    add_row(FUNC_PUSH_HEAD, 64'h8000_0000_0000_0000, 32'h8000_0000, IKOD_DEPTH - 1, 1'b0,
            STATUS_OK, 0);
    add_row(FUNC_PUSH_TAIL, 64'hdead_beef, 32'h1, 1, 1'b1, STATUS_FULL, IKOD_DEPTH);
    add_row(FUNC_PUSH_HEAD, 64'hdead_beef, 32'h2, 1, 1'b1, STATUS_FULL, IKOD_DEPTH);
    add_row(FUNC_REMOVE,    64'h8000_0000_0000_0007, '0, 1, 1'b0, STATUS_OK, 0);
    add_row(FUNC_POP_HEAD,  '0, '0, 1, 1'b0, STATUS_OK, 0);
    add_row(FUNC_POP_TAIL,  '0, '0, 1, 1'b0, STATUS_OK, 0);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_ops[r]) begin
      for (int unsigned k = 0; k < directed_ops[r].reps; k++) begin
        row = directed_ops[r];
        row.id = directed_ops[r].id + k;
        row.handle = directed_ops[r].handle + k;
        send_op(row);
      end
    end

    for (int p = 0; p < 4; p++) begin
      src_idle_pct = SRC_IDLE[p];
      sink_stall_pct = SINK_STALL[p];
      foreach (id_pool[j]) id_pool[j] = {$urandom(), $urandom()};
      for (int unsigned n = 0; n < RANDOM_ITEMS / 4; n++) send_op(random_op());
    end
    s_axis_tvalid <= 1'b0;

    while (pending_results.size() > 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### files.f
rtl/ikod_pkg.sv
rtl/id_keyed_ordered_deque.sv
rtl/ikod_checker.sv
tb/id_keyed_ordered_deque_tb.sv
